// ----- rtl/core/slm_pkg.sv -----
// shared types and constants for the sorted list merge block
// used by the channel interfaces, the controller, the datapath and the top level
// no dependencies
package slm_pkg;

   // default sizes for the top level parameters
   localparam int DEF_LIST_DEPTH = 32;
   localparam int DEF_DATA_WIDTH = 32;

   // fixed width of the value fields on both channels
   localparam int IO_WIDTH = 32;

   // request kinds
   typedef enum logic [1:0] {
      KIND_APPEND_FIRST  = 2'd0,
      KIND_APPEND_SECOND = 2'd1,
      KIND_MERGE         = 2'd2
   } kind_type;

   // controller to datapath commands
   typedef struct packed {
      logic append_first;
      logic append_second;
      logic clear_flag;
      logic emit;
   } slm_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic out_free;
      logic lists_empty;
      logic last_pending;
   } slm_status_type;

endpackage

// ----- rtl/core/slm_req_if.sv -----
// request channel: append and merge items into the block
// depends on slm_pkg for the field width
interface slm_req_if import slm_pkg::*;;
   logic                       valid;
   logic                       ready;
   logic [1:0]                 kind;
   logic signed [IO_WIDTH-1:0] value;

   modport source (output valid, output kind, output value, input ready);
   modport sink (input valid, input kind, input value, output ready);
endinterface

// ----- rtl/core/slm_rsp_if.sv -----
// response channel: merged elements out of the block
// depends on slm_pkg for the field width
interface slm_rsp_if import slm_pkg::*;;
   logic                       valid;
   logic                       ready;
   logic signed [IO_WIDTH-1:0] merged_value;
   logic                       from_second;
   logic                       last;
   logic                       overflow;

   modport source (output valid, output merged_value, output from_second,
                   output last, output overflow, input ready);
   modport sink (input valid, input merged_value, input from_second,
                 input last, input overflow, output ready);
endinterface

// ----- rtl/core/sorted_list_merge.sv -----
// top level of the sorted list merge block
// depends on slm_pkg, slm_req_if, slm_rsp_if, slm_ctrl and slm_datapath
//
// Usage:
//   req_ch carries items of three kinds: append to the first list, append
//   to the second list, merge. Kind 3 is accepted and ignored. Each list
//   holds up to LIST_DEPTH elements; an append to a full list is dropped and
//   sets a sticky overflow flag reported on every result of the next merge.
//   A merge item sends every stored element out on rsp_ch in ascending
//   order (first list wins ties), last set on the final one; afterwards
//   both lists and the flag are cleared. A merge of two empty lists gives
//   no result and only clears the flag.
// Timing:
//   A merge is accepted, passes through a prep state in which the list heads
//   are read from the list memories, then produces one result per cycle
//   while rsp_ch does not stall. The block takes no new item until the last
//   result is in the output register.
//   A stall on rsp_ch holds the result register and pauses the merge.
// Reset: synchronous, clears counts, read pointers, flag, state and the output valid bit.
module sorted_list_merge import slm_pkg::*; #(
   parameter int LIST_DEPTH = DEF_LIST_DEPTH,
   parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
   input logic     clock,
   input logic     reset,
   slm_req_if.sink   req_ch,
   slm_rsp_if.source rsp_ch
);

   slm_cmd_type    cmd;
   slm_status_type status;

   // sequencing of appends and merges
   slm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_kind  (kind_type'(req_ch.kind)),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // list storage and merge datapath
   slm_datapath #(
      .LIST_DEPTH (LIST_DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_value        (req_ch.value),
      .rsp_ready        (rsp_ch.ready),
      .status           (status),
      .rsp_valid        (rsp_ch.valid),
      .rsp_merged_value (rsp_ch.merged_value),
      .rsp_from_second  (rsp_ch.from_second),
      .rsp_last         (rsp_ch.last),
      .rsp_overflow     (rsp_ch.overflow)
   );

endmodule

// ----- rtl/core/slm_ctrl.sv -----
// control state machine of the sorted list merge block
// depends on slm_pkg for the kind codes and the command / status structs
module slm_ctrl import slm_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   input  kind_type       req_kind,
   output logic           req_ready,
   input  slm_status_type status,
   output slm_cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_PREP  = 3'b010,
      ST_MERGE = 3'b100
   } state_type;

   state_type state_ff, state_in;

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = (state_ff == ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (req_kind)
                  KIND_APPEND_FIRST:  cmd.append_first = 1'b1;
                  KIND_APPEND_SECOND: cmd.append_second = 1'b1;
                  KIND_MERGE: begin
                     // nothing stored: only the sticky flag is cleared
                     if (status.lists_empty) cmd.clear_flag = 1'b1;
                     else state_in = ST_PREP;
                  end
                  default: ;
               endcase
            end
         end
         // prep state: lets the list heads be read after the last append
         ST_PREP: state_in = ST_MERGE;
         ST_MERGE: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               if (status.last_pending) state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

endmodule

// ----- rtl/core/slm_datapath.sv -----
// list storage, head compare and output register of the sorted list merge block
// depends on slm_pkg for the command / status structs and the io width
module slm_datapath import slm_pkg::*; #(
   parameter int LIST_DEPTH = DEF_LIST_DEPTH,
   parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  slm_cmd_type                cmd,
   input  logic signed [IO_WIDTH-1:0] req_value,
   input  logic                       rsp_ready,
   output slm_status_type             status,
   output logic                       rsp_valid,
   output logic signed [IO_WIDTH-1:0] rsp_merged_value,
   output logic                       rsp_from_second,
   output logic                       rsp_last,
   output logic                       rsp_overflow
);

   localparam int CNT_W = $clog2(LIST_DEPTH + 1);
   localparam int IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(LIST_DEPTH);

   logic signed [DATA_WIDTH-1:0] mem_first [LIST_DEPTH];
   logic signed [DATA_WIDTH-1:0] mem_second [LIST_DEPTH];

   logic [CNT_W-1:0] cnt_first_ff, cnt_first_in;
   logic [CNT_W-1:0] cnt_second_ff, cnt_second_in;
   logic [CNT_W-1:0] ptr_first_ff, ptr_first_in;
   logic [CNT_W-1:0] ptr_second_ff, ptr_second_in;
   logic             dropped_ff, dropped_in;
   logic signed [DATA_WIDTH-1:0] head_first_ff, head_second_ff;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [IO_WIDTH-1:0] rsp_value_ff;
   logic                       rsp_second_ff, rsp_last_ff, rsp_overflow_ff;

   logic signed [DATA_WIDTH-1:0] store_value;
   logic                         full_first, full_second;
   logic                         avail_first, avail_second, take_first;
   logic [CNT_W:0]               taken_sum, total_sum;
   logic                         finish;

   // stored form of the incoming value: sign-extended or truncated
   assign store_value = DATA_WIDTH'(req_value);

   assign full_first   = (cnt_first_ff == FULL_COUNT);
   assign full_second  = (cnt_second_ff == FULL_COUNT);
   assign avail_first  = (ptr_first_ff < cnt_first_ff);
   assign avail_second = (ptr_second_ff < cnt_second_ff);

   // head compare, first list wins ties
   assign take_first = avail_first && (!avail_second || (head_first_ff <= head_second_ff));

   assign taken_sum = {1'b0, ptr_first_ff} + {1'b0, ptr_second_ff} + (CNT_W+1)'(1);
   assign total_sum = {1'b0, cnt_first_ff} + {1'b0, cnt_second_ff};

   assign status.out_free     = !rsp_valid_ff || rsp_ready;
   assign status.lists_empty  = (cnt_first_ff == '0) && (cnt_second_ff == '0);
   assign status.last_pending = (taken_sum == total_sum);

   assign finish = cmd.emit && status.last_pending;

   // counts, read pointers and the sticky drop flag
   always_comb begin
      cnt_first_in  = cnt_first_ff;
      cnt_second_in = cnt_second_ff;
      ptr_first_in  = ptr_first_ff;
      ptr_second_in = ptr_second_ff;
      dropped_in    = dropped_ff;
      if (cmd.append_first) begin
         if (full_first) dropped_in = 1'b1;
         else cnt_first_in = cnt_first_ff + CNT_W'(1);
      end
      if (cmd.append_second) begin
         if (full_second) dropped_in = 1'b1;
         else cnt_second_in = cnt_second_ff + CNT_W'(1);
      end
      if (cmd.clear_flag) dropped_in = 1'b0;
      if (cmd.emit) begin
         if (take_first) ptr_first_in = ptr_first_ff + CNT_W'(1);
         else ptr_second_in = ptr_second_ff + CNT_W'(1);
      end
      // end of merge: both lists empty again
      if (finish) begin
         cnt_first_in  = '0;
         cnt_second_in = '0;
         ptr_first_in  = '0;
         ptr_second_in = '0;
         dropped_in    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_first_ff  <= '0;
         cnt_second_ff <= '0;
         ptr_first_ff  <= '0;
         ptr_second_ff <= '0;
         dropped_ff    <= 1'b0;
      end else begin
         cnt_first_ff  <= cnt_first_in;
         cnt_second_ff <= cnt_second_in;
         ptr_first_ff  <= ptr_first_in;
         ptr_second_ff <= ptr_second_in;
         dropped_ff    <= dropped_in;
      end
   end

   // list memories: write at the fill count, registered read at the next head
   always_ff @(posedge clock) begin
      if (cmd.append_first && !full_first)
         mem_first[cnt_first_ff[IDX_W-1:0]] <= store_value;
      if (cmd.append_second && !full_second)
         mem_second[cnt_second_ff[IDX_W-1:0]] <= store_value;
      if (ptr_first_in < FULL_COUNT)
         head_first_ff <= mem_first[ptr_first_in[IDX_W-1:0]];
      if (ptr_second_in < FULL_COUNT)
         head_second_ff <= mem_second[ptr_second_in[IDX_W-1:0]];
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_value_ff    <= take_first ? IO_WIDTH'(head_first_ff)
                                       : IO_WIDTH'(head_second_ff);
         rsp_second_ff   <= !take_first;
         rsp_last_ff     <= status.last_pending;
         rsp_overflow_ff <= dropped_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_merged_value = rsp_value_ff;
   assign rsp_from_second  = rsp_second_ff;
   assign rsp_last         = rsp_last_ff;
   assign rsp_overflow     = rsp_overflow_ff;

endmodule
